// ----- hdl/bbpq_pkg.sv -----
// Shared types, constants and codes for the bounded bypass priority queue.
`timescale 1ns / 1ps

package bbpq_pkg;

   localparam int DEPTH    = 16;
   localparam int ID_WIDTH = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int BYP_W    = 4;

   localparam logic [BYP_W-1:0] MAX_BYPASS_RESET = BYP_W'(2);

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] customer_id;
      logic        is_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_id;
      logic        out_priority;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic                pri;
      logic [BYP_W-1:0]    byp;
   } slot_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic                enq;
      logic                deq;
      logic                bypass_on;
      logic [ID_WIDTH-1:0] id;
      logic                pri;
      logic [BYP_W-1:0]    max_bypass;
   } cmd_type;

endpackage

// ----- hdl/bbpq_cell.sv -----
// One queue slot: holds an entry, shifts toward head on pop, away from head on bypass.
`timescale 1ns / 1ps

module bbpq_cell (
   input  logic               clock,
   input  bbpq_pkg::cmd_type  cmd,
   input  logic               occ,
   input  logic               at_tail,
   input  bbpq_pkg::slot_type left_slot,
   input  bbpq_pkg::slot_type right_slot,
   input  logic               all_right_in,
   output logic               all_left_out,
   input  logic               moved_left_in,
   output logic               moved_out,
   output bbpq_pkg::slot_type slot_out
);
   import bbpq_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;
   logic     passable;

   // ordinary entry still under its bypass limit
   assign passable     = occ && !slot_ff.pri && (slot_ff.byp < cmd.max_bypass);
   // every occupied slot from here to the tail can be passed
   assign all_left_out = all_right_in && (!occ || passable);
   assign moved_out    = cmd.bypass_on && passable && all_right_in;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.deq) begin
         slot_in = right_slot;
      end else if (cmd.enq) begin
         if (moved_left_in) begin
            slot_in.id  = left_slot.id;
            slot_in.pri = 1'b0;
            slot_in.byp = left_slot.byp + BYP_W'(1);
         end else if (moved_out || at_tail) begin
            slot_in.id  = cmd.id;
            slot_in.pri = cmd.pri;
            slot_in.byp = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_out = slot_ff;

endmodule

// ----- hdl/bounded_bypass_priority_queue.sv -----
// Top level of the bounded bypass priority queue: control, chain of slot cells, result register.
`timescale 1ns / 1ps

// Usage
//   req channel: req_valid / req_stall / req_data. A transfer happens on a rising
//   edge with req_valid high and req_stall low. opcode enqueues (ordinary or
//   priority) or pops the head.
//   rsp channel: rsp_valid / rsp_stall / rsp_data. Exactly one result per request:
//   status, popped id and priority bit, and occupancy after the operation.
//   csr port: csr_wr_en / csr_wr_data write max_bypass (reset value 2); write it
//   only while the queue is quiet.
// Timing
//   Every request resolves across the row of slot cells: each cell
//   decides locally whether it shifts back (and counts a bypass), takes the new
//   entry, or shifts forward on a pop. The result is registered, so it appears in
//   the cycle after the request transfer. Throughput is one item per cycle
//   while rsp_stall is low, set by the single result register.
// Stall
//   While a result waits under rsp_stall, req_stall is raised; a new request is
//   taken in the same cycle the pending result transfers.
// Reset
//   Synchronous, active high: queue empty, no result pending, max_bypass = 2.
//   Slot contents are not cleared; only occupied slots are ever read.

module bounded_bypass_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bbpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbpq_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data
);
   import bbpq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [BYP_W-1:0] max_bypass_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic     accept;
   logic     full, empty;
   cmd_type  cmd;

   slot_type   slots [DEPTH];
   logic [DEPTH-1:0] all_left;
   logic [DEPTH-1:0] moved;
   logic [DEPTH-1:0] occ;
   logic [DEPTH-1:0] at_tail;

   // A new request may enter when the result register is free or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.enq        = accept && (req_data.opcode == OP_ENQ) && !full;
      cmd.deq        = accept && (req_data.opcode == OP_DEQ) && !empty;
      cmd.bypass_on  = cmd.enq && req_data.is_priority;
      cmd.id         = ID_WIDTH'(req_data.customer_id);
      cmd.pri        = req_data.is_priority;
      cmd.max_bypass = max_bypass_ff;
   end

   // Row of slot cells, head in cell 0. The bypass-eligibility chain runs from
   // the tail end toward the head; the "shifted back" chain runs the other way.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type left_s, right_s;
      logic     all_r, moved_l;

      assign occ[i]     = (CNT_W'(i) < count_ff);
      assign at_tail[i] = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_s  = '0;
         assign moved_l = 1'b0;
      end else begin : g_mid
         assign left_s  = slots[i-1];
         assign moved_l = moved[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_s = '0;
         assign all_r   = 1'b1;
      end else begin : g_inner
         assign right_s = slots[i+1];
         assign all_r   = all_left[i+1];
      end

      bbpq_cell u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .occ           (occ[i]),
         .at_tail       (at_tail[i]),
         .left_slot     (left_s),
         .right_slot    (right_s),
         .all_right_in  (all_r),
         .all_left_out  (all_left[i]),
         .moved_left_in (moved_l),
         .moved_out     (moved[i]),
         .slot_out      (slots[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = STATUS_OK;
         rsp_in.out_id       = '0;
         rsp_in.out_priority = 1'b0;
         rsp_in.occupancy    = 5'(count_in);
         if (req_data.opcode == OP_ENQ) begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end
         end else if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.out_id       = 16'(slots[0].id);
            rsp_in.out_priority = slots[0].pri;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         max_bypass_ff <= MAX_BYPASS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_bypass_ff <= csr_wr_data;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a request");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |->
         (rsp_ff.occupancy == 5'(DEPTH)))
      else $error("full status with partial occupancy");

   a_single_insert: assert property (@(posedge clock) disable iff (reset)
      $onehot0(moved & ~{moved[DEPTH-2:0], 1'b0}))
      else $error("bypass run is not contiguous");

endmodule
